>>> design/lwf_pkg.sv
// Package for the window fill command encoder.
// Shared constants, step and queue entry types. No dependencies.
package lwf_pkg;

    localparam int DEF_SCREEN_WIDTH  = 240;
    localparam int DEF_SCREEN_HEIGHT = 320;

    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_RECT  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
    localparam logic [7:0] BYTE_MASK        = 8'hFF;

    localparam logic [16:0] RUN_COUNT_MAX = 17'h1FFFF;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        S_COL_CMD,
        S_COL_START_HI,
        S_COL_START_LO,
        S_COL_END_HI,
        S_COL_END_LO,
        S_ROW_CMD,
        S_ROW_START_HI,
        S_ROW_START_LO,
        S_ROW_END_HI,
        S_ROW_END_LO,
        S_MEM_CMD,
        S_RUN
    } step_t;

    typedef struct packed {
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
        logic [15:0] color;
        logic [16:0] count;
    } window_t;

endpackage

>>> design/lcd_window_fill_command_encoder_top.sv
// Top level of the window fill command encoder.
// Instantiates lwf_front, lwf_queue and lwf_back; uses lwf_pkg.
//
// Input channel s_*: one draw request per transfer (pixel, rectangle, clear).
// Output channel m_*: the controller transfer sequence for each request:
//   column-set command, four column bytes, row-set command, four row bytes,
//   memory-write command, then one run transfer (color, pixel count) with
//   m_last high. Requests off screen, of zero size or of unused mode give
//   no transfers.
// The column-set command of a request passes the front stage register, the
//   queue and the output register on its way out.
// Throughput: one transfer per cycle on the output register while the queue
//   holds an entry and m_ready is high; dropped requests never reach the queue.
//   The front end clips the window and forms the pixel count in a registered
//   stage, and a two-entry queue lets it take new requests while the back end
//   is still sequencing.
// Reset (aresetn low, synchronous) empties the front stage, the queue and the
//   output register. When m_ready is low the output holds; the queue fills,
//   then s_ready drops.
module lcd_window_fill_command_encoder_top #(
    parameter int SCREEN_WIDTH  = lwf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lwf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_x,
    input  logic [15:0] s_y,
    input  logic [15:0] s_width,
    input  logic [15:0] s_height,
    input  logic [15:0] s_color,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_value,
    output logic [16:0] m_run_count,
    output logic        m_last
);
    import lwf_pkg::*;

    window_t push_data, pop_data;
    logic    push, push_ready, pop_valid, pop;

    lwf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_x      (s_x),
        .s_y      (s_y),
        .s_width  (s_width),
        .s_height (s_height),
        .s_color  (s_color),
        .q_push   (push),
        .q_ready  (push_ready),
        .q_data   (push_data)
    );

    lwf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    lwf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_pop       (pop),
        .q_data      (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_value     (m_value),
        .m_run_count (m_run_count),
        .m_last      (m_last)
    );

    a_last_is_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_kind == KIND_RUN)
        else $error("last flag on a non-run transfer");

    a_byte_count_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_RUN |-> m_run_count == 17'd1 && m_value[15:8] == 8'd0)
        else $error("byte transfer with bad count or value");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_RUN |-> m_run_count != 17'd0)
        else $error("empty run emitted");

    a_pop_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid && !(push && !push_ready))
        else $error("queue pop without entry");

endmodule

>>> design/lwf_front.sv
// Front end: accepts draw requests, drops empty, off-screen and unused-mode ones, clips the window,
// then forms end coordinates and pixel count for the queue. Uses lwf_pkg.
module lwf_front #(
    parameter int SCREEN_WIDTH  = lwf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lwf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [15:0]       s_x,
    input  logic [15:0]       s_y,
    input  logic [15:0]       s_width,
    input  logic [15:0]       s_height,
    input  logic [15:0]       s_color,
    output logic              q_push,
    input  logic              q_ready,
    output lwf_pkg::window_t  q_data
);
    import lwf_pkg::*;

    localparam int WW = $clog2(SCREEN_WIDTH + 1);
    localparam int HW = $clog2(SCREEN_HEIGHT + 1);
    localparam int PW = WW + HW;
    localparam logic [15:0] SW16 = 16'(SCREEN_WIDTH);
    localparam logic [15:0] SH16 = 16'(SCREEN_HEIGHT);

    logic          a_valid_reg, a_valid_next;
    logic [15:0]   a_x_reg, a_y_reg, a_color_reg;
    logic [WW-1:0] a_w_reg, a_w_next;
    logic [HW-1:0] a_h_reg, a_h_next;
    logic [15:0]   a_x_next, a_y_next;

    logic          s_fire, keep;
    logic          on_screen;
    logic [16:0]   sum_x, sum_y;
    logic [15:0]   w_clip, h_clip;

    logic [PW-1:0]    product;
    logic [PW+16:0]   prod_ext;

    assign s_ready = !a_valid_reg || q_ready;
    assign s_fire  = s_valid && s_ready;

    assign on_screen = (s_x < SW16) && (s_y < SH16);
    assign sum_x  = {1'b0, s_x} + {1'b0, s_width};
    assign sum_y  = {1'b0, s_y} + {1'b0, s_height};
    assign w_clip = (sum_x > {1'b0, SW16}) ? (SW16 - s_x) : s_width;
    assign h_clip = (sum_y > {1'b0, SH16}) ? (SH16 - s_y) : s_height;

    always_comb begin
        keep     = 1'b0;
        a_x_next = s_x;
        a_y_next = s_y;
        a_w_next = WW'(1);
        a_h_next = HW'(1);
        case (s_mode)
            MODE_CLEAR: begin
                keep     = 1'b1;
                a_x_next = 16'd0;
                a_y_next = 16'd0;
                a_w_next = WW'(SCREEN_WIDTH);
                a_h_next = HW'(SCREEN_HEIGHT);
            end
            MODE_PIXEL: begin
                keep = on_screen;
            end
            MODE_RECT: begin
                keep     = on_screen && (s_width != 16'd0) && (s_height != 16'd0);
                a_w_next = w_clip[WW-1:0];
                a_h_next = h_clip[HW-1:0];
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = keep;
        end else if (q_push) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_x_reg     <= a_x_next;
            a_y_reg     <= a_y_next;
            a_w_reg     <= a_w_next;
            a_h_reg     <= a_h_next;
            a_color_reg <= s_color;
        end
    end

    assign q_push   = a_valid_reg && q_ready;
    assign product  = PW'(a_w_reg) * PW'(a_h_reg);
    assign prod_ext = {17'd0, product};

    always_comb begin
        q_data.x0    = a_x_reg;
        q_data.y0    = a_y_reg;
        q_data.x1    = a_x_reg + 16'(a_w_reg) - 16'd1;
        q_data.y1    = a_y_reg + 16'(a_h_reg) - 16'd1;
        q_data.color = a_color_reg;
        q_data.count = (prod_ext > (PW+17)'(RUN_COUNT_MAX)) ? RUN_COUNT_MAX
                                                            : prod_ext[16:0];
    end

endmodule

>>> design/lwf_queue.sv
// Short register queue between front and back end.
// Holds window_t entries from lwf_pkg.
module lwf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    output logic              push_ready,
    input  lwf_pkg::window_t  push_data,
    output logic              pop_valid,
    input  logic              pop,
    output lwf_pkg::window_t  pop_data
);
    import lwf_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    window_t         mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/lwf_back.sv
// Back end: walks the twelve-step transfer sequence for the queue head
// into a registered output stage. Uses lwf_pkg.
module lwf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_pop,
    input  lwf_pkg::window_t  q_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [15:0]       m_value,
    output logic [16:0]       m_run_count,
    output logic              m_last
);
    import lwf_pkg::*;

    step_t       step_reg, step_next;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] value_reg, value_next;
    logic [16:0] count_reg, count_next;
    logic        last_reg, last_next;
    logic        load;

    assign load  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = load && (step_reg == S_RUN);

    always_comb begin
        step_next = step_reg;
        if (load) begin
            case (step_reg)
                S_COL_CMD:      step_next = S_COL_START_HI;
                S_COL_START_HI: step_next = S_COL_START_LO;
                S_COL_START_LO: step_next = S_COL_END_HI;
                S_COL_END_HI:   step_next = S_COL_END_LO;
                S_COL_END_LO:   step_next = S_ROW_CMD;
                S_ROW_CMD:      step_next = S_ROW_START_HI;
                S_ROW_START_HI: step_next = S_ROW_START_LO;
                S_ROW_START_LO: step_next = S_ROW_END_HI;
                S_ROW_END_HI:   step_next = S_ROW_END_LO;
                S_ROW_END_LO:   step_next = S_MEM_CMD;
                S_MEM_CMD:      step_next = S_RUN;
                default:        step_next = S_COL_CMD;
            endcase
        end
    end

    always_comb begin
        kind_next  = KIND_DATA;
        value_next = 16'd0;
        count_next = 17'd1;
        last_next  = 1'b0;
        case (step_reg)
            S_COL_CMD: begin
                kind_next  = KIND_CMD;
                value_next = {8'd0, CMD_COLUMN_SET};
            end
            S_COL_START_HI: value_next = {8'd0, q_data.x0[15:8] & BYTE_MASK};
            S_COL_START_LO: value_next = {8'd0, q_data.x0[7:0] & BYTE_MASK};
            S_COL_END_HI:   value_next = {8'd0, q_data.x1[15:8] & BYTE_MASK};
            S_COL_END_LO:   value_next = {8'd0, q_data.x1[7:0] & BYTE_MASK};
            S_ROW_CMD: begin
                kind_next  = KIND_CMD;
                value_next = {8'd0, CMD_ROW_SET};
            end
            S_ROW_START_HI: value_next = {8'd0, q_data.y0[15:8] & BYTE_MASK};
            S_ROW_START_LO: value_next = {8'd0, q_data.y0[7:0] & BYTE_MASK};
            S_ROW_END_HI:   value_next = {8'd0, q_data.y1[15:8] & BYTE_MASK};
            S_ROW_END_LO:   value_next = {8'd0, q_data.y1[7:0] & BYTE_MASK};
            S_MEM_CMD: begin
                kind_next  = KIND_CMD;
                value_next = {8'd0, CMD_MEMORY_WRITE};
            end
            S_RUN: begin
                kind_next  = KIND_RUN;
                value_next = q_data.color;
                count_next = q_data.count;
                last_next  = 1'b1;
            end
            default: begin
                kind_next = KIND_CMD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= S_COL_CMD;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = kind_reg;
    assign m_value     = value_reg;
    assign m_run_count = count_reg;
    assign m_last      = last_reg;

endmodule
